// ----- hw/rtl/zfsf_pkg.sv -----
// ============================================================================
// zfsf_pkg
// Shared constants, header table and control types of the finish filter.
// ============================================================================
package zfsf_pkg;

  // Header length as configured, capped at the table size
  localparam int SEQ_LEN = 20;
  localparam int HDR_MAX = 20;
  localparam int HDR_LEN = (SEQ_LEN > HDR_MAX) ? HDR_MAX : SEQ_LEN;
  localparam int IDX_W   = $clog2(HDR_MAX);

  localparam logic [7:0] BYTE_O = 8'h4F;
  localparam logic [1:0] O_DROP_MAX = 2'd2;

  // Finish header bytes, first byte is '*'
  localparam logic [7:0] HDR_BYTES [HDR_MAX] = '{
    8'h2A, 8'h2A, 8'h18, 8'h42, 8'h30, 8'h38, 8'h30, 8'h30, 8'h30, 8'h30,
    8'h30, 8'h30, 8'h30, 8'h30, 8'h30, 8'h32, 8'h32, 8'h64, 8'h0D, 8'h8A
  };

  // Stream phase after reset and after the header completes
  typedef enum logic [1:0] {
    PH_SCAN    = 2'd0,
    PH_DROP_O  = 2'd1,
    PH_SAVE    = 2'd2,
    PH_DISCARD = 2'd3
  } phase_t;

  // Datapath operations issued by the controller
  typedef enum logic [2:0] {
    OP_NONE,
    OP_PASS,
    OP_DROP_O,
    OP_ADVANCE,
    OP_FOUND,
    OP_MISS,
    OP_REPLAY,
    OP_TAIL
  } op_t;

  typedef struct packed {
    op_t op;
  } ctl_cmd_t;

  typedef struct packed {
    logic   slot_free;   // output register empty or draining this cycle
    logic   hit_first;   // input byte equals first header byte
    logic   hit_cur;     // input byte equals the next expected header byte
    logic   mi_zero;     // no partial match held
    logic   mi_last;     // next match completes the header
    logic   o_drop_ok;   // input is 'O' and drop budget remains
    logic   rep_done;    // replay counter on its last byte
    logic   tail_pend;   // held byte follows the replay
    phase_t phase;
  } dp_stat_t;

endpackage

// ----- hw/rtl/zfsf_ctrl.sv -----
// ============================================================================
// zfsf_ctrl
// Controller: accepts bytes, picks the datapath operation, sequences replays.
// ============================================================================
module zfsf_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  zfsf_pkg::dp_stat_t stat,
  output zfsf_pkg::ctl_cmd_t cmd
);
  import zfsf_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REPLAY,
    ST_TAIL
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign in_ready = (state == ST_IDLE) && stat.slot_free;
  assign accept   = in_valid && in_ready;

  // Operation select and next state
  always_comb begin
    cmd.op     = OP_NONE;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (stat.phase)
            PH_SCAN: begin
              if (stat.mi_zero && !stat.hit_first) begin
                cmd.op = OP_PASS;
              end else if (stat.hit_cur) begin
                if (stat.mi_last) begin
                  cmd.op     = OP_FOUND;
                  state_next = ST_REPLAY;
                end else begin
                  cmd.op = OP_ADVANCE;
                end
              end else begin
                cmd.op     = OP_MISS;
                state_next = ST_REPLAY;
              end
            end
            PH_DROP_O: cmd.op = stat.o_drop_ok ? OP_DROP_O : OP_PASS;
            PH_SAVE:   cmd.op = OP_PASS;
            default:   cmd.op = OP_NONE;
          endcase
        end
      end
      ST_REPLAY: begin
        if (stat.slot_free) begin
          cmd.op = OP_REPLAY;
          if (stat.rep_done) begin
            state_next = stat.tail_pend ? ST_TAIL : ST_IDLE;
          end
        end
      end
      ST_TAIL: begin
        if (stat.slot_free) begin
          cmd.op     = OP_TAIL;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- hw/rtl/zfsf_datapath.sv -----
// ============================================================================
// zfsf_datapath
// Datapath: match index, replay counter, phase, mode and output register.
// ============================================================================
module zfsf_datapath (
  input  logic               clk,
  input  logic               rst,
  input  logic [7:0]         in_byte,
  input  logic               cfg_we,
  input  logic               cfg_mode,
  input  zfsf_pkg::ctl_cmd_t cmd,
  output zfsf_pkg::dp_stat_t stat,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [7:0]         out_byte,
  output logic               out_kind,
  output logic               finish_found,
  output logic               last_of_run
);
  import zfsf_pkg::*;

  logic [IDX_W-1:0] match_index;
  logic [IDX_W-1:0] rep_cnt;
  logic [IDX_W-1:0] rep_last;
  logic             rep_found;
  logic             tail_pend;
  logic [7:0]       held_byte;
  logic [1:0]       o_dropped;
  logic             mode;
  phase_t           phase;
  logic             load;

  // Status toward the controller
  assign stat.slot_free = !out_valid || out_ready;
  assign stat.hit_first = (in_byte == HDR_BYTES[0]);
  assign stat.hit_cur   = (in_byte == HDR_BYTES[match_index]);
  assign stat.mi_zero   = (match_index == '0);
  assign stat.mi_last   = (match_index == IDX_W'(HDR_LEN - 1));
  assign stat.o_drop_ok = (in_byte == BYTE_O) && (o_dropped < O_DROP_MAX);
  assign stat.rep_done  = (rep_cnt == rep_last);
  assign stat.tail_pend = tail_pend;
  assign stat.phase     = phase;

  assign load = (cmd.op == OP_PASS) || (cmd.op == OP_REPLAY) || (cmd.op == OP_TAIL);

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      match_index <= '0;
      o_dropped   <= '0;
      phase       <= PH_SCAN;
      mode        <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        mode <= cfg_mode;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (cmd.op)
        OP_PASS: begin
          if (phase == PH_DROP_O) begin
            phase <= PH_SAVE;
          end
        end
        OP_DROP_O:  o_dropped   <= o_dropped + 2'd1;
        OP_ADVANCE: match_index <= match_index + IDX_W'(1);
        OP_FOUND: begin
          match_index <= '0;
          o_dropped   <= '0;
          phase       <= mode ? PH_DISCARD : PH_DROP_O;
        end
        OP_MISS: match_index <= stat.hit_first ? IDX_W'(1) : '0;
        default: ;
      endcase
    end
  end

  // Replay bookkeeping and output payload
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_PASS: begin
        out_byte     <= in_byte;
        out_kind     <= (phase != PH_SCAN);
        finish_found <= 1'b0;
        last_of_run  <= 1'b1;
      end
      OP_FOUND: begin
        rep_cnt   <= '0;
        rep_last  <= IDX_W'(HDR_LEN - 1);
        rep_found <= 1'b1;
        tail_pend <= 1'b0;
      end
      OP_MISS: begin
        rep_cnt   <= '0;
        rep_last  <= match_index - IDX_W'(1);
        rep_found <= 1'b0;
        tail_pend <= !stat.hit_first;
        held_byte <= in_byte;
      end
      OP_REPLAY: begin
        out_byte     <= HDR_BYTES[rep_cnt];
        out_kind     <= 1'b0;
        finish_found <= rep_found;
        last_of_run  <= stat.rep_done && !tail_pend;
        rep_cnt      <= rep_cnt + IDX_W'(1);
      end
      OP_TAIL: begin
        out_byte     <= held_byte;
        out_kind     <= 1'b0;
        finish_found <= 1'b0;
        last_of_run  <= 1'b1;
      end
      default: ;
    endcase
  end

endmodule

// ----- hw/rtl/zmodem_finish_sequence_filter_top.sv -----
// ============================================================================
// zmodem_finish_sequence_filter_top
// Byte stream filter that detects and tags the ZMODEM finish header.
// ============================================================================
// Usage:
//   s_* carries one stream byte per transaction in s_tdata[7:0]. m_* returns
//   zero or more result bytes per input byte; m_tlast marks the last result
//   caused by one input. cfg_valid/cfg_data write the after-finish mode; the
//   port is always ready and the value is sampled when the header completes.
// Flow:
//   A passed byte appears in the cycle after it is accepted, and a new byte
//   is taken every cycle while no replay runs and m_tready is high. A
//   broken partial match replays the held prefix from the header table,
//   one byte per cycle while m_tready is high: the breaking byte is taken
//   first, then the held bytes are emitted, then the breaking byte itself
//   when it is passed on. A completed header is emitted whole from the
//   table. Held and dropped bytes give no result.
// Reset:
//   rst clears the scanner to its start, the mode to 0 and the output valid.
// Stall:
//   While m_tready is low the result holds in the output register and
//   s_tready drops once that register is full.
// ============================================================================
module zmodem_finish_sequence_filter_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic [1:0] m_tuser,   // [0] out_kind, [1] finish_found
  output logic       m_tlast,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [0:0] cfg_data   // [0] after_finish_mode
);
  import zfsf_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;
  logic     out_kind;
  logic     finish_found;

  assign cfg_ready = 1'b1;
  assign m_tuser   = {finish_found, out_kind};

  // Controller
  zfsf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath
  zfsf_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .in_byte      (s_tdata),
    .cfg_we       (cfg_valid),
    .cfg_mode     (cfg_data[0]),
    .cmd          (cmd),
    .stat         (stat),
    .out_ready    (m_tready),
    .out_valid    (m_tvalid),
    .out_byte     (m_tdata),
    .out_kind     (out_kind),
    .finish_found (finish_found),
    .last_of_run  (m_tlast)
  );

endmodule

// ----- hw/rtl/zfsf_checker.sv -----
// ============================================================================
// zfsf_checker
// Port-level checks of the finish filter, bound to the top level.
// ============================================================================
module zfsf_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic [1:0] m_tuser,
  input logic       m_tlast
);
  import zfsf_pkg::*;

  // Output register is empty after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // A stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("stalled result changed");

  // No input transaction while a stalled result fills the output register
  a_in_blocked: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |-> !m_tvalid || m_tready)
    else $error("input taken while output stalled");

  // Header bytes are never tagged as saved
  a_found_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> !m_tuser[0])
    else $error("found byte tagged as saved");

  // Last byte of a completed header is the table's final byte
  a_found_end: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] && m_tlast |-> m_tdata == HDR_BYTES[HDR_LEN - 1])
    else $error("completed header ends on wrong byte");

endmodule

bind zmodem_finish_sequence_filter_top zfsf_checker u_zfsf_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

// ----- sim/zmodem_finish_sequence_filter_top_tb.sv -----
// ============================================================================
// zmodem_finish_sequence_filter_top_tb
// Self-checking testbench of the finish-header stream filter. A behavioral
// predictor tracks scan phase, held prefix and the 'O' budget and queues the
// bytes the filter must emit. A monitor compares every output transaction
// with the oldest queued byte. Both stream sides idle and stall at random.
// ============================================================================
module zmodem_finish_sequence_filter_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import zfsf_pkg::*;

  localparam int CLK_HALF      = 6;
  localparam int SETTLE_CYCLES = 30;      // covers a full header burst
  localparam int CYCLE_LIMIT   = 200000;
  localparam logic [7:0] BYTE_STAR  = 8'h2A;
  localparam logic [7:0] BYTE_FLUSH = 8'h41;  // matches no header position

  // One byte the filter is expected to emit
  typedef struct {
    logic [7:0] data;
    logic       kind;
    logic       found;
    logic       last;
  } filt_byte_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;   // [7:0] in_byte
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;           // [7:0] out_byte
  logic [1:0] m_tuser;           // [0] out_kind, [1] finish_found
  logic       m_tlast;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [0:0] cfg_data = 1'b0;   // [0] after_finish_mode

  // Predictor state
  filt_byte_t  expected_out[$];
  phase_t      flt_phase = PH_SCAN;
  int          held_len = 0;
  int          o_dropped = 0;
  logic        mode_reg = 1'b0;

  int          err_count = 0;
  int unsigned cycle_count = 0;
  bit          steady = 1'b0;     // no idling on either side while set

  zmodem_finish_sequence_filter_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("zmodem_finish_sequence_filter_top_tb: FAIL");
      $finish;
    end
  end

  // Output backpressure
  always @(posedge clk) begin
    if (steady) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= 31);
    end
  end

  // Compare each output transaction with the oldest expected byte
  always @(posedge clk) begin : check_out
    filt_byte_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_out.size() == 0) begin
        $error("unexpected output byte: got %h", m_tdata);
        err_count++;
      end else begin
        want = expected_out.pop_front();
        if (m_tdata !== want.data) begin
          $error("out_byte: expected %h, got %h", want.data, m_tdata);
          err_count++;
        end
        if (m_tuser[0] !== want.kind) begin
          $error("out_kind: expected %b, got %b", want.kind, m_tuser[0]);
          err_count++;
        end
        if (m_tuser[1] !== want.found) begin
          $error("finish_found: expected %b, got %b", want.found, m_tuser[1]);
          err_count++;
        end
        if (m_tlast !== want.last) begin
          $error("last_of_run: expected %b, got %b", want.last, m_tlast);
          err_count++;
        end
      end
    end
  end

  // Advance the predictor by one accepted byte and queue what it emits
  task automatic filter_byte(input logic [7:0] b);
    filt_byte_t run[$];
    filt_byte_t r;
    r.last = 1'b0;
    case (flt_phase)
      PH_SCAN: begin
        if (held_len == 0 && b != HDR_BYTES[0]) begin
          r.data = b; r.kind = 1'b0; r.found = 1'b0;
          run.push_back(r);
        end else if (b == HDR_BYTES[held_len]) begin
          held_len++;
          if (held_len >= HDR_LEN) begin
            for (int i = 0; i < HDR_LEN; i++) begin
              r.data = HDR_BYTES[i]; r.kind = 1'b0; r.found = 1'b1;
              run.push_back(r);
            end
            held_len  = 0;
            o_dropped = 0;
            flt_phase = mode_reg ? PH_DISCARD : PH_DROP_O;
          end
        end else begin
          // broken prefix: replay it, then rescan the breaking byte
          for (int i = 0; i < held_len; i++) begin
            r.data = HDR_BYTES[i]; r.kind = 1'b0; r.found = 1'b0;
            run.push_back(r);
          end
          held_len = 0;
          if (b == HDR_BYTES[0]) begin
            held_len = 1;
          end else begin
            r.data = b; r.kind = 1'b0; r.found = 1'b0;
            run.push_back(r);
          end
        end
      end
      PH_DROP_O: begin
        if (b == BYTE_O && o_dropped < int'(O_DROP_MAX)) begin
          o_dropped++;
        end else begin
          flt_phase = PH_SAVE;
          r.data = b; r.kind = 1'b1; r.found = 1'b0;
          run.push_back(r);
        end
      end
      PH_SAVE: begin
        r.data = b; r.kind = 1'b1; r.found = 1'b0;
        run.push_back(r);
      end
      default: ;
    endcase
    if (run.size() > 0) run[run.size() - 1].last = 1'b1;
    foreach (run[i]) expected_out.push_back(run[i]);
  endtask

  // Offer one byte, with a random gap unless in a steady stretch
  task automatic send_byte(input logic [7:0] b);
    while (!steady && $urandom_range(0, 99) < 31) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    filter_byte(b);
  endtask

  // Stop sending and wait until the filter has emitted everything
  task automatic drain_output();
    s_tvalid <= 1'b0;
    while (expected_out.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mode register write, only with the filter idle
  task automatic write_mode(input logic v);
    drain_output();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    mode_reg = v;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Header prefix of len bytes, broken by a byte that does not continue it
  task automatic send_broken_prefix(input int len);
    logic [7:0] brk;
    brk = 8'($urandom_range(0, 255));
    if (brk == HDR_BYTES[len]) brk = brk ^ 8'h01;
    for (int i = 0; i < len; i++) send_byte(HDR_BYTES[i]);
    send_byte(brk);
  endtask

  task automatic test_mode_writes();
    write_mode(1'b1);
    write_mode(1'b0);
  endtask

  // Plain pass-through and short broken prefixes
  task automatic test_directed_scan();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(BYTE_O);
    send_byte(8'h80);
    send_byte(8'h7F);
    // single held '*' broken by a plain byte
    send_byte(BYTE_STAR);
    send_byte(8'h00);
    // third '*' breaks "**" and is held again
    send_byte(BYTE_STAR);
    send_byte(BYTE_STAR);
    send_byte(BYTE_STAR);
    // continue from the held '*' to five bytes, then break
    send_byte(BYTE_STAR);
    send_byte(HDR_BYTES[2]);
    send_byte(HDR_BYTES[3]);
    send_byte(HDR_BYTES[4]);
    send_byte(8'hFF);
    // 'O' passes through while scanning
    send_byte(BYTE_STAR);
    send_byte(BYTE_O);
    // break with '*' after three bytes, then flush the new hold
    send_byte(BYTE_STAR);
    send_byte(BYTE_STAR);
    send_byte(HDR_BYTES[2]);
    send_byte(BYTE_STAR);
    send_byte(BYTE_FLUSH);
  endtask

  // Mostly header fragments with random breaks, some noise
  task automatic test_random_scan();
    int sent;
    int pick;
    sent = 0;
    steady = 1'b1;
    send_broken_prefix(HDR_LEN - 1);   // near miss on the final byte
    sent += HDR_LEN;
    while (sent < 60) begin
      if (sent >= 30) steady = 1'b0;
      if (sent >= 40 && sent < 45) begin
        write_mode(1'($urandom_range(0, 1)));
        sent = 45;
      end
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        send_byte(8'($urandom_range(0, 255)));
        sent += 1;
      end else if (pick < 85) begin
        pick = $urandom_range(1, 4);
        send_broken_prefix(pick);
        sent += pick + 1;
      end else begin
        pick = $urandom_range(5, HDR_LEN - 1);
        send_broken_prefix(pick);
        sent += pick + 1;
      end
    end
  endtask

  // Complete the header; the mode set here is the one latched
  task automatic test_finish_header();
    write_mode(($urandom_range(0, 3) == 0) ? 1'b1 : 1'b0);
    steady = 1'b1;
    send_byte(BYTE_FLUSH);
    for (int i = 0; i < HDR_LEN; i++) send_byte(HDR_BYTES[i]);
    steady = 1'b0;
  endtask

  // 'O' dropping, saving or discarding after the header
  task automatic test_after_finish();
    int n_o;
    n_o = ($urandom_range(0, 1) == 0) ? 3 : $urandom_range(0, 2);
    for (int i = 0; i < n_o; i++) send_byte(BYTE_O);
    send_byte(8'($urandom_range(0, 255)));
    for (int i = 0; i < 12; i++) begin
      send_byte(($urandom_range(0, 3) == 0) ? BYTE_O : 8'($urandom_range(0, 255)));
    end
    // a late write must not change the latched behavior
    write_mode(~mode_reg);
    for (int i = 0; i < 12; i++) send_byte(8'($urandom_range(0, 255)));
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_mode_writes();
    test_directed_scan();
    test_random_scan();
    test_finish_header();
    test_after_finish();
    drain_output();
    if (err_count == 0) begin
      $display("zmodem_finish_sequence_filter_top_tb: PASS");
    end else begin
      $display("zmodem_finish_sequence_filter_top_tb: FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/zfsf_pkg.sv
hw/rtl/zfsf_ctrl.sv
hw/rtl/zfsf_datapath.sv
hw/rtl/zmodem_finish_sequence_filter_top.sv
hw/rtl/zfsf_checker.sv
sim/zmodem_finish_sequence_filter_top_tb.sv
